[hw/rtl/ldd_pkg.sv]
// Shared constants, command codes and types of the lock deadlock detector.
package ldd_pkg;

	localparam int NUM_PROCS_DEF = 16;
	localparam int NUM_LOCKS_DEF = 16;

	localparam int CMD_W   = 2;
	localparam int PID_W   = 4;
	localparam int LOCK_W  = 4;

	// tdata widths, padded to whole bytes
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WAKE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	typedef struct packed {
		logic done;
		logic deadlock;
	} sweep_sts_t;

endpackage

[hw/rtl/lock_deadlock_detector_unit.sv]
// Top level: command decode, matrix RAM read-modify-write and result register.
//
//  channel | dir | payload (lsb first)                                | width
//  s_*     | in  | command[1:0] pid[5:2] lock[9:6] queue_empty[10]    | 16
//  m_*     | out | granted[0] deadlock[1]                             | 8
//
// Grant, wake grant, release and ignored commands go through accept with RAM read, row
// update and result load. A blocked acquire adds the detection sweep: each pass reads
// every process row once from the RAM port, for up to NUM_PROCS + 1 passes. One command
// is in work at a time; s_tready is high only while idle.
// The result register lets the next command enter while m_tready holds the last one.
// Reset clears the free vector to all free and the row valid bits; RAM rows need no clear.
module lock_deadlock_detector_unit #(
	parameter int NUM_PROCS = ldd_pkg::NUM_PROCS_DEF,
	parameter int NUM_LOCKS = ldd_pkg::NUM_LOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ldd_pkg::S_TDATA_W-1:0]  s_tdata,  // command, pid, lock, queue_empty
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ldd_pkg::M_TDATA_W-1:0]  m_tdata   // granted, deadlock
);

	localparam int PW = $clog2(NUM_PROCS);
	localparam int NL = NUM_LOCKS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_DET  = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;

	logic [2:0]                    state_q;
	logic [ldd_pkg::CMD_W-1:0]     cmd_q;
	logic [ldd_pkg::PID_W-1:0]     pid_q;
	logic [ldd_pkg::LOCK_W-1:0]    lock_q;
	logic                          qe_q;
	logic [NL-1:0]                 free_q;
	logic [NUM_PROCS-1:0]          row_vld_q;
	logic                          vld_s1;
	logic                          granted_q;
	logic                          dead_q;
	logic                          m_tvalid_q;
	logic                          m_granted_q;
	logic                          m_dead_q;

	logic                          accept;
	logic [ldd_pkg::PID_W-1:0]     in_pid;
	logic                          rd_en;
	logic [PW-1:0]                 raddr;
	logic [2*NL-1:0]               rdata;
	logic [NL-1:0]                 row_alloc;
	logic [NL-1:0]                 row_req;
	logic                          we;
	logic [NL-1:0]                 new_alloc;
	logic [NL-1:0]                 new_req;
	logic [NL-1:0]                 lbit;
	logic                          in_range;
	logic                          blocked;
	logic                          grant;
	logic                          out_load;
	logic                          sw_rd_en;
	logic [PW-1:0]                 sw_addr;
	ldd_pkg::sweep_sts_t           sw_sts;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign in_pid   = s_tdata[5:2];

	assign rd_en = accept | sw_rd_en;
	assign raddr = (state_q == ST_DET) ? sw_addr : PW'(in_pid);

	assign row_alloc = vld_s1 ? rdata[NL-1:0] : '0;
	assign row_req   = vld_s1 ? rdata[2*NL-1:NL] : '0;

	assign in_range = (32'(pid_q) < NUM_PROCS) && (32'(lock_q) < NUM_LOCKS);
	assign lbit     = NL'(1) << lock_q;

	// result register takes a new result when empty or being drained
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// row update for the command in EXEC
	always_comb begin
		we        = 1'b0;
		blocked   = 1'b0;
		grant     = 1'b0;
		new_alloc = row_alloc;
		new_req   = row_req;
		if (in_range) begin
			case (cmd_q)
				ldd_pkg::CMD_ACQUIRE: begin
					we = 1'b1;
					if ((free_q & lbit) != '0) begin
						new_req   = row_req & ~lbit;
						new_alloc = row_alloc | lbit;
						grant     = 1'b1;
					end else begin
						new_req = row_req | lbit;
						blocked = 1'b1;
					end
				end
				ldd_pkg::CMD_WAKE: begin
					we        = 1'b1;
					new_req   = row_req & ~lbit;
					new_alloc = row_alloc | lbit;
				end
				ldd_pkg::CMD_RELEASE: begin
					we        = 1'b1;
					new_alloc = row_alloc & ~lbit;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	ldd_ram #(
		.WIDTH(2 * NL),
		.DEPTH(NUM_PROCS)
	) u_ram (
		.clk   (clk),
		.we    (we && (state_q == ST_EXEC)),
		.waddr (PW'(pid_q)),
		.wdata ({new_req, new_alloc}),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	ldd_sweep #(
		.NUM_PROCS(NUM_PROCS),
		.NUM_LOCKS(NUM_LOCKS)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    ((state_q == ST_EXEC) && blocked),
		.free_vec (free_q),
		.rd_en    (sw_rd_en),
		.rd_addr  (sw_addr),
		.rd_vld   (vld_s1),
		.rd_alloc (rdata[NL-1:0]),
		.rd_req   (rdata[2*NL-1:NL]),
		.sts      (sw_sts)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tdata[1:0];
			pid_q  <= in_pid;
			lock_q <= s_tdata[9:6];
			qe_q   <= s_tdata[10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			free_q      <= '1;
			row_vld_q   <= '0;
			vld_s1      <= 1'b0;
			granted_q   <= 1'b0;
			dead_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_granted_q <= 1'b0;
			m_dead_q    <= 1'b0;
		end else begin
			if (rd_en) begin
				vld_s1 <= row_vld_q[raddr];
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					granted_q <= grant;
					dead_q    <= 1'b0;
					state_q   <= blocked ? ST_DET : ST_OUT;
					if (we) begin
						row_vld_q[PW'(pid_q)] <= 1'b1;
					end
					if (in_range) begin
						case (cmd_q)
							ldd_pkg::CMD_ACQUIRE: begin
								if (!blocked) begin
									free_q <= free_q & ~lbit;
								end
							end
							ldd_pkg::CMD_WAKE: begin
								free_q <= free_q & ~lbit;
							end
							ldd_pkg::CMD_RELEASE: begin
								if (qe_q) begin
									free_q <= free_q | lbit;
								end
							end
							default: begin
								free_q <= free_q;
							end
						endcase
					end
				end
				ST_DET: begin
					if (sw_sts.done) begin
						dead_q  <= sw_sts.deadlock;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the result register is free
					if (out_load) begin
						m_granted_q <= granted_q;
						m_dead_q    <= dead_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(ldd_pkg::M_TDATA_W - 2){1'b0}}, m_dead_q, m_granted_q};

endmodule

[hw/rtl/ldd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ldd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/ldd_sweep.sv]
// Deadlock detection: repeated passes over the process rows held in the matrix RAM.
module ldd_sweep #(
	parameter int NUM_PROCS = ldd_pkg::NUM_PROCS_DEF,
	parameter int NUM_LOCKS = ldd_pkg::NUM_LOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_LOCKS-1:0]         free_vec,
	output logic                         rd_en,
	output logic [$clog2(NUM_PROCS)-1:0] rd_addr,
	input  logic                         rd_vld,
	input  logic [NUM_LOCKS-1:0]         rd_alloc,
	input  logic [NUM_LOCKS-1:0]         rd_req,
	output ldd_pkg::sweep_sts_t          sts
);

	localparam int PW = $clog2(NUM_PROCS);
	localparam logic [PW-1:0] LAST = PW'(NUM_PROCS - 1);

	logic                 act_q;
	logic                 iss_q;
	logic [PW-1:0]        idx_q;
	logic                 rv_s1;
	logic [PW-1:0]        ridx_s1;
	logic [NUM_LOCKS-1:0] work_q;
	logic [NUM_PROCS-1:0] fin_q;
	logic                 prog_q;
	logic                 done_q;
	logic                 dead_q;

	logic [NUM_LOCKS-1:0] alloc;
	logic [NUM_LOCKS-1:0] req;
	logic                 can;
	logic [NUM_PROCS-1:0] fin_nxt;
	logic                 pass_end;
	logic                 sweep_end;

	assign rd_en   = act_q & iss_q;
	assign rd_addr = idx_q;

	// never-written rows read as zero
	assign alloc = rd_vld ? rd_alloc : '0;
	assign req   = rd_vld ? rd_req : '0;
	// a process holding nothing counts as finished; it adds nothing to work
	assign can   = !fin_q[ridx_s1] && ((alloc == '0) || ((req & ~work_q) == '0));

	// last row of a pass evaluated; stop when the whole pass made no progress
	assign pass_end  = act_q && rv_s1 && (ridx_s1 == LAST);
	assign sweep_end = pass_end && !prog_q && !can;

	always_comb begin
		fin_nxt = fin_q;
		if (can) begin
			fin_nxt[ridx_s1] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			iss_q   <= 1'b0;
			idx_q   <= '0;
			rv_s1   <= 1'b0;
			ridx_s1 <= '0;
			work_q  <= '0;
			fin_q   <= '0;
			prog_q  <= 1'b0;
			done_q  <= 1'b0;
			dead_q  <= 1'b0;
		end else begin
			// start only arrives while idle, so no read is in flight then
			rv_s1  <= rd_en;
			done_q <= sweep_end;
			if (rd_en) begin
				ridx_s1 <= idx_q;
				if (idx_q == LAST) begin
					iss_q <= 1'b0;
				end else begin
					idx_q <= idx_q + PW'(1);
				end
			end
			if (start) begin
				act_q  <= 1'b1;
				iss_q  <= 1'b1;
				idx_q  <= '0;
				work_q <= free_vec;
				fin_q  <= '0;
				prog_q <= 1'b0;
			end else if (act_q && rv_s1) begin
				if (can) begin
					work_q <= work_q | alloc;
				end
				fin_q <= fin_nxt;
				if (ridx_s1 == LAST) begin
					if (sweep_end) begin
						act_q  <= 1'b0;
						dead_q <= (fin_nxt != '1);
					end else begin
						// another pass
						iss_q  <= 1'b1;
						idx_q  <= '0;
						prog_q <= 1'b0;
					end
				end else if (can) begin
					prog_q <= 1'b1;
				end
			end
		end
	end

	assign sts.done     = done_q;
	assign sts.deadlock = dead_q;

endmodule

[hw/rtl/ldd_chk.sv]
// Port-level checker for the lock deadlock detector, bound to the top level.
module ldd_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [ldd_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ldd_pkg::M_TDATA_W-1:0] m_tdata
);

	// one request in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a request is in work");

	// a lock granted at once never reports deadlock
	a_grant_xor_dead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("granted and deadlock both set");

	// a new result only follows a busy cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without a request in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind lock_deadlock_detector_unit ldd_chk u_ldd_chk (.*);

[tb/sv/ldd_result_checker.sv]
// Result checker of the lock deadlock detector: tracks the lock tables and checks every result.
module ldd_result_checker #(
	parameter int NUM_PROCS = ldd_pkg::NUM_PROCS_DEF,
	parameter int NUM_LOCKS = ldd_pkg::NUM_LOCKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ldd_pkg::S_TDATA_W-1:0]  s_tdata,  // command, pid, lock, queue_empty
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ldd_pkg::M_TDATA_W-1:0]  m_tdata,  // granted, deadlock
	output int                             error_count,
	output int                             outstanding
);

	typedef struct packed {
		logic granted;
		logic deadlock;
	} lock_answer_t;

	logic [NUM_LOCKS-1:0] held_locks   [NUM_PROCS];
	logic [NUM_LOCKS-1:0] wanted_locks [NUM_PROCS];
	logic [NUM_LOCKS-1:0] free_locks;
	lock_answer_t         pending_answers [$];

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Single-instance detection: finish every process whose requests fit in work.
	function automatic logic find_deadlock();
		logic [NUM_LOCKS-1:0] work;
		logic [NUM_PROCS-1:0] finished;
		logic                 progress;
		work     = free_locks;
		finished = '0;
		for (int i = 0; i < NUM_PROCS; i++)
			if (held_locks[i] == '0)
				finished[i] = 1'b1;
		for (int pass = 0; pass < NUM_PROCS; pass++) begin
			progress = 1'b0;
			for (int i = 0; i < NUM_PROCS; i++) begin
				if (!finished[i] && (wanted_locks[i] & ~work) == '0) begin
					work        = work | held_locks[i];
					finished[i] = 1'b1;
					progress    = 1'b1;
				end
			end
			if (!progress)
				break;
		end
		return (finished != {NUM_PROCS{1'b1}});
	endfunction

	function automatic lock_answer_t apply_command(input logic [ldd_pkg::S_TDATA_W-1:0] word);
		logic [ldd_pkg::CMD_W-1:0]  cmd;
		logic [ldd_pkg::PID_W-1:0]  pid;
		logic [ldd_pkg::LOCK_W-1:0] lk;
		logic                       qe;
		lock_answer_t               ans;
		cmd = word[1:0];
		pid = word[5:2];
		lk  = word[9:6];
		qe  = word[10];
		ans = '0;
		if (pid < NUM_PROCS && lk < NUM_LOCKS) begin
			case (cmd)
				ldd_pkg::CMD_ACQUIRE: begin
					if (free_locks[lk]) begin
						free_locks[lk]        = 1'b0;
						wanted_locks[pid][lk] = 1'b0;
						held_locks[pid][lk]   = 1'b1;
						ans.granted           = 1'b1;
					end else begin
						wanted_locks[pid][lk] = 1'b1;
						ans.deadlock          = find_deadlock();
					end
				end
				ldd_pkg::CMD_WAKE: begin
					wanted_locks[pid][lk] = 1'b0;
					held_locks[pid][lk]   = 1'b1;
					free_locks[lk]        = 1'b0;
				end
				ldd_pkg::CMD_RELEASE: begin
					held_locks[pid][lk] = 1'b0;
					if (qe)
						free_locks[lk] = 1'b1;
				end
				default: ;
			endcase
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lock_answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROCS; i++) begin
				held_locks[i]   = '0;
				wanted_locks[i] = '0;
			end
			free_locks = {NUM_LOCKS{1'b1}};
			pending_answers.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_answers.size() == 0) begin
					report_error($sformatf("result %0h with no request pending", m_tdata));
				end else begin
					want = pending_answers.pop_front();
					if (m_tdata[0] !== want.granted)
						report_error($sformatf("granted: expected %0b, got %0b",
							want.granted, m_tdata[0]));
					if (m_tdata[1] !== want.deadlock)
						report_error($sformatf("deadlock: expected %0b, got %0b",
							want.deadlock, m_tdata[1]));
				end
			end
			if (s_tvalid && s_tready)
				pending_answers.push_back(apply_command(s_tdata));
			outstanding = pending_answers.size();
		end
	end

	initial begin
		error_count = 0;
		outstanding = 0;
	end

endmodule

[tb/sv/tb_lock_deadlock_detector_unit.sv]
// Testbench top of the lock deadlock detector: clock, reset, request traffic and verdict.
module tb_lock_deadlock_detector_unit;

	localparam int CMD_W     = ldd_pkg::CMD_W;
	localparam int PID_W     = ldd_pkg::PID_W;
	localparam int LOCK_W    = ldd_pkg::LOCK_W;
	localparam int S_TDATA_W = ldd_pkg::S_TDATA_W;
	localparam int M_TDATA_W = ldd_pkg::M_TDATA_W;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS  = 1800;
	localparam int PHASES        = 3;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 400;
	localparam int LIMIT_CYCLES  = 3_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;  // command, pid, lock, queue_empty
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;  // granted, deadlock
	int                    error_count;
	int                    outstanding;

	int                    phase = 0;
	int                    items_sent = 0;
	int                    cycle_count = 0;
	logic                  long_hold_done = 1'b0;

	// rough view of the lock table, only used to shape requests
	logic [15:0]           busy_locks = '0;
	logic [PID_W-1:0]      lock_owner [16];
	logic [15:0]           lock_waiters [16];

	always #2 clk = ~clk;

	lock_deadlock_detector_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ldd_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.error_count (error_count),
		.outstanding (outstanding)
	);

	function automatic int sender_idle_pct(input int ph);
		return (ph == 0) ? 10 : (ph == 1) ? 87 : 0;
	endfunction

	function automatic int receiver_idle_pct(input int ph);
		return (ph == 0) ? 87 : (ph == 1) ? 10 : 0;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [PID_W-1:0] pid,
			input logic [LOCK_W-1:0] lk, input logic qe);
		logic [S_TDATA_W-1:0] word;
		word       = '0;
		word[1:0]  = cmd;
		word[5:2]  = pid;
		word[9:6]  = lk;
		word[10]   = qe;
		while ($urandom_range(0, 99) < sender_idle_pct(phase)) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (cmd != CMD_UNUSED)
			items_sent++;
		case (cmd)
			ldd_pkg::CMD_ACQUIRE: begin
				if (!busy_locks[lk]) begin
					busy_locks[lk]        = 1'b1;
					lock_owner[lk]        = pid;
					lock_waiters[lk][pid] = 1'b0;
				end else begin
					lock_waiters[lk][pid] = 1'b1;
				end
			end
			ldd_pkg::CMD_WAKE: begin
				busy_locks[lk]        = 1'b1;
				lock_owner[lk]        = pid;
				lock_waiters[lk][pid] = 1'b0;
			end
			ldd_pkg::CMD_RELEASE: if (qe) busy_locks[lk] = 1'b0;
			default: ;
		endcase
	endtask

	// Mostly well-formed lock traffic on a few hot locks, with some raw noise.
	task automatic random_step();
		logic [PID_W-1:0]  pid;
		logic [LOCK_W-1:0] lk;
		logic [PID_W-1:0]  waker;
		logic              qe;
		int                roll;
		int                start;
		pid  = ($urandom_range(0, 3) == 0) ? PID_W'($urandom_range(0, 15))
			: PID_W'($urandom_range(0, 5));
		lk   = ($urandom_range(0, 3) == 0) ? LOCK_W'($urandom_range(0, 15))
			: LOCK_W'($urandom_range(0, 3));
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			send_cmd(CMD_W'($urandom_range(0, 3)), PID_W'($urandom_range(0, 15)),
				LOCK_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		end else if (!busy_locks[lk]) begin
			send_cmd(ldd_pkg::CMD_ACQUIRE, pid, lk, 1'($urandom_range(0, 1)));
		end else if (roll < 55) begin
			send_cmd(ldd_pkg::CMD_ACQUIRE, pid, lk, 1'b0);
		end else if (roll < 60) begin
			// holder asks again
			send_cmd(ldd_pkg::CMD_ACQUIRE, lock_owner[lk], lk, 1'b0);
		end else begin
			qe = (lock_waiters[lk] == '0);
			send_cmd(ldd_pkg::CMD_RELEASE, lock_owner[lk], lk, qe);
			if (!qe) begin
				// hand off to one waiter, picked from a random start
				start = $urandom_range(0, 15);
				waker = PID_W'(start);
				for (int k = 15; k >= 0; k--)
					if (lock_waiters[lk][(start + k) % 16])
						waker = PID_W'((start + k) % 16);
				send_cmd(ldd_pkg::CMD_WAKE, waker, lk, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// receiver side: random stalls per phase, one long hold-off at the start of the last phase
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 2 && !long_hold_done) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct(phase));
			end
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		for (int i = 0; i < 16; i++) begin
			lock_owner[i]   = '0;
			lock_waiters[i] = '0;
		end
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: grants, a two-process cycle, handoffs and the odd cases
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd0,  4'd0,  1'b0);
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd15, 4'd15, 1'b1);
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd15, 4'd0,  1'b0);
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd0,  4'd15, 1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd0,  4'd0,  1'b0);
		send_cmd(ldd_pkg::CMD_WAKE,    4'd15, 4'd0,  1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd15, 4'd0,  1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd15, 4'd15, 1'b0);
		send_cmd(ldd_pkg::CMD_WAKE,    4'd0,  4'd15, 1'b0);
		// holder acquires its own lock
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd0,  4'd15, 1'b0);
		send_cmd(ldd_pkg::CMD_WAKE,    4'd0,  4'd15, 1'b0);
		// release by a process that does not hold the lock
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd3,  4'd15, 1'b1);
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd9,  4'd15, 1'b0);
		// wake grant with nothing requested
		send_cmd(ldd_pkg::CMD_WAKE,    4'd5,  4'd7,  1'b0);
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd6,  4'd7,  1'b1);
		send_cmd(CMD_UNUSED,           4'd15, 4'd15, 1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd5,  4'd7,  1'b0);
		send_cmd(ldd_pkg::CMD_WAKE,    4'd6,  4'd7,  1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd6,  4'd7,  1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd0,  4'd15, 1'b0);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd9,  4'd15, 1'b1);
		send_cmd(ldd_pkg::CMD_ACQUIRE, 4'd10, 4'd5,  1'b1);
		send_cmd(ldd_pkg::CMD_RELEASE, 4'd10, 4'd5,  1'b1);
		wait_all_results();
		@(negedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			phase      = ph;
			items_sent = 0;
			while (items_sent < RANDOM_ITEMS / PHASES)
				random_step();
			// sender pause: let every result drain before the next phase
			wait_all_results();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ldd_pkg.sv
hw/rtl/ldd_ram.sv
hw/rtl/ldd_sweep.sv
hw/rtl/lock_deadlock_detector_unit.sv
hw/rtl/ldd_chk.sv
tb/sv/ldd_result_checker.sv
tb/sv/tb_lock_deadlock_detector_unit.sv
